>>> rtl/core/lcdn_pkg.sv
// ----------------------------------------------------------------------------
// lcdn_pkg
// Shared types and constants of the 4-bit character LCD request sequencer.
// ----------------------------------------------------------------------------
package lcdn_pkg;

    // request kinds on the input tuser
    localparam logic [3:0] REQ_INIT    = 4'd0;
    localparam logic [3:0] REQ_CHAR    = 4'd1;
    localparam logic [3:0] REQ_CURSOR  = 4'd2;
    localparam logic [3:0] REQ_LINES   = 4'd3;
    localparam logic [3:0] REQ_CUR_ON  = 4'd4;
    localparam logic [3:0] REQ_BLINK   = 4'd5;
    localparam logic [3:0] REQ_DISP_ON = 4'd6;
    localparam logic [3:0] REQ_CLEAR   = 4'd7;
    localparam logic [3:0] REQ_SHR     = 4'd8;
    localparam logic [3:0] REQ_SHL     = 4'd9;

    // configuration register indexes
    localparam logic [1:0] CFG_SETTLE   = 2'd0;
    localparam logic [1:0] CFG_POWER_UP = 2'd1;
    localparam logic [1:0] CFG_INIT_GAP = 2'd2;
    localparam logic [1:0] CFG_CLEAR_GAP = 2'd3;

    localparam logic [9:0]  SETTLE_RST    = 10'd60;
    localparam logic [15:0] POWER_UP_RST  = 16'd20000;
    localparam logic [15:0] INIT_GAP_RST  = 16'd5000;
    localparam logic [15:0] CLEAR_GAP_RST = 16'd3000;

    // LCD command bytes and shadow values
    localparam logic [7:0] DC_RST      = 8'h0F;
    localparam logic [7:0] FS_RST      = 8'h38;
    localparam logic [7:0] FS_INIT     = 8'h28;
    localparam logic [7:0] DDRAM_ROW1  = 8'h80;
    localparam logic [7:0] DDRAM_ROW2  = 8'hC0;
    localparam logic [7:0] CMD_SHR     = 8'h1C;
    localparam logic [7:0] CMD_SHL     = 8'h18;
    localparam logic [7:0] CMD_CLEAR   = 8'h01;
    localparam logic [7:0] FS_TWO_LINE = 8'h08;
    localparam logic [7:0] DC_DISP     = 8'h04;
    localparam logic [7:0] DC_CURSOR   = 8'h02;
    localparam logic [7:0] DC_BLINK    = 8'h01;
    localparam logic [3:0] NIB_INIT_A  = 4'h3;
    localparam logic [3:0] NIB_INIT_B  = 4'h2;

    localparam logic [4:0] MAX_SHIFT = 5'd31;

    // command queue depth
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // work kinds handed from front to back
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_INIT = 1'b1;

    typedef struct packed {
        logic       op;       // OP_BYTE or OP_INIT
        logic       rs;       // RS level
        logic [7:0] data;     // byte to send (display-control byte for init)
        logic       clr_gap;  // add clear gap after each low-nibble strobe
        logic [4:0] count;    // repetitions of the byte, 1 or more
    } t_desc;

    typedef struct packed {
        logic [9:0]  settle_us;
        logic [15:0] power_up_us;
        logic [15:0] init_gap_us;
        logic [15:0] clear_gap_us;
    } t_cfg;

endpackage

>>> rtl/core/char_lcd_nibble_interface.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_interface
// Character LCD request sequencer for a 4-bit bus: requests in, enable strobe
// records (RS, nibble, waits) out, high nibble first.
// ----------------------------------------------------------------------------
// A request is taken whenever the two-entry command queue has room, so up to one
// request can wait behind the one being sent, which holds the head. The strobe
// sequencer then issues one strobe record per cycle while the output is not
// stalled: two for a byte, eight for init, 2*n for a shift by n (up to 62).
// With the sequencer idle, a taken request is first written into the queue and
// its first strobe is then loaded into the output register. A request then
// occupies the sequencer until its last strobe is loaded. Requests that send
// nothing (unknown kind, zero character, bad row, zero shift count) leave the
// shadow bytes alone and are dropped by the front end, so they never reach the
// sequencer. Waits are not counted here: pre_wait_us and post_wait_us are
// handed on with each strobe. Configuration writes are accepted every cycle.
// ----------------------------------------------------------------------------
module char_lcd_nibble_interface
    import lcdn_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // char_code[7:0], row[9:8], col[14:10], turn_on[15],
                                       // line_count[17:16], shift_count[22:18], zero[23]
    input  logic [3:0]  s_axis_tuser,  // req_type[3:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // nibble[3:0], pre_wait_us[19:4],
                                       // post_wait_us[36:20], zero[39:37]
    output logic        m_axis_tuser,  // reg_select
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg        r_cfg;
    logic        w_push;
    t_desc       w_push_desc;
    logic        w_full;
    logic        w_pop;
    logic        w_head_valid;
    t_desc       w_head;
    logic [3:0]  w_nibble;
    logic [15:0] w_pre;
    logic [16:0] w_post;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.settle_us    <= SETTLE_RST;
            r_cfg.power_up_us  <= POWER_UP_RST;
            r_cfg.init_gap_us  <= INIT_GAP_RST;
            r_cfg.clear_gap_us <= CLEAR_GAP_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SETTLE:    r_cfg.settle_us    <= i_cfg_data[9:0];
                CFG_POWER_UP:  r_cfg.power_up_us  <= i_cfg_data;
                CFG_INIT_GAP:  r_cfg.init_gap_us  <= i_cfg_data;
                CFG_CLEAR_GAP: r_cfg.clear_gap_us <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    lcdn_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_req_type    (s_axis_tuser),
        .i_char_code   (s_axis_tdata[7:0]),
        .i_row         (s_axis_tdata[9:8]),
        .i_col         (s_axis_tdata[14:10]),
        .i_turn_on     (s_axis_tdata[15]),
        .i_line_count  (s_axis_tdata[17:16]),
        .i_shift_count (s_axis_tdata[22:18]),
        .i_q_full      (w_full),
        .o_push        (w_push),
        .o_desc        (w_push_desc)
    );

    lcdn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_desc  (w_push_desc),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_desc  (w_head)
    );

    lcdn_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_rs         (m_axis_tuser),
        .o_nibble     (w_nibble),
        .o_pre_us     (w_pre),
        .o_post_us    (w_post),
        .o_last       (m_axis_tlast)
    );

    assign m_axis_tdata = {3'd0, w_post, w_pre, w_nibble};

endmodule

>>> rtl/core/lcdn_front.sv
// ----------------------------------------------------------------------------
// lcdn_front
// Accepts requests, keeps the shadow bytes and turns each request into a
// command word for the strobe sequencer.
// ----------------------------------------------------------------------------
module lcdn_front
    import lcdn_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [3:0]  i_req_type,
    input  logic [7:0]  i_char_code,
    input  logic [1:0]  i_row,
    input  logic [4:0]  i_col,
    input  logic        i_turn_on,
    input  logic [1:0]  i_line_count,
    input  logic [4:0]  i_shift_count,
    input  logic        i_q_full,
    output logic        o_push,
    output t_desc       o_desc
);

    logic [7:0] r_disp_ctrl, n_disp_ctrl;
    logic [7:0] r_func_set,  n_func_set;
    logic       w_emit;
    logic       w_take;
    logic [7:0] w_addr;
    logic [4:0] w_cnt;

    assign o_ready = !i_q_full;
    assign w_take  = i_valid && o_ready;

    always_comb begin
        n_disp_ctrl   = r_disp_ctrl;
        n_func_set    = r_func_set;
        w_emit        = 1'b0;
        w_addr        = {4'd0, i_col[3:0] + 4'd15};
        w_cnt         = (i_shift_count > MAX_SHIFT) ? MAX_SHIFT : i_shift_count;
        o_desc.op     = OP_BYTE;
        o_desc.rs     = 1'b0;
        o_desc.data   = 8'd0;
        o_desc.clr_gap = 1'b0;
        o_desc.count  = 5'd1;
        unique case (i_req_type) inside
            REQ_INIT: begin
                n_func_set  = FS_INIT;
                n_disp_ctrl = r_disp_ctrl | DC_DISP;
                o_desc.op   = OP_INIT;
                o_desc.data = n_disp_ctrl;
                w_emit      = 1'b1;
            end
            REQ_CHAR: begin
                o_desc.rs   = 1'b1;
                o_desc.data = i_char_code;
                w_emit      = (i_char_code != 8'd0);
            end
            REQ_CURSOR: begin
                o_desc.data = w_addr | ((i_row == 2'd2) ? DDRAM_ROW2 : DDRAM_ROW1);
                w_emit      = (i_row == 2'd1) || (i_row == 2'd2);
            end
            REQ_LINES: begin
                if (i_line_count == 2'd1) begin
                    n_func_set = r_func_set & ~FS_TWO_LINE;
                end else if (i_line_count == 2'd2) begin
                    n_func_set = r_func_set | FS_TWO_LINE;
                end
                o_desc.data = n_func_set;
                w_emit      = 1'b1;
            end
            REQ_CUR_ON, REQ_BLINK, REQ_DISP_ON: begin
                if (i_turn_on) begin
                    n_disp_ctrl = r_disp_ctrl | ((i_req_type == REQ_CUR_ON) ? DC_CURSOR :
                                  (i_req_type == REQ_BLINK) ? DC_BLINK : DC_DISP);
                end else begin
                    n_disp_ctrl = r_disp_ctrl & ~((i_req_type == REQ_CUR_ON) ? DC_CURSOR :
                                  (i_req_type == REQ_BLINK) ? DC_BLINK : DC_DISP);
                end
                o_desc.data = n_disp_ctrl;
                w_emit      = 1'b1;
            end
            REQ_CLEAR: begin
                o_desc.data    = CMD_CLEAR;
                o_desc.clr_gap = 1'b1;
                w_emit         = 1'b1;
            end
            REQ_SHR, REQ_SHL: begin
                o_desc.data  = (i_req_type == REQ_SHR) ? CMD_SHR : CMD_SHL;
                o_desc.count = w_cnt;
                w_emit       = (w_cnt != 5'd0);
            end
            default: begin
                // unknown kinds do nothing
            end
        endcase
    end

    assign o_push = w_take && w_emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disp_ctrl <= DC_RST;
            r_func_set  <= FS_RST;
        end else if (w_take) begin
            r_disp_ctrl <= n_disp_ctrl;
            r_func_set  <= n_func_set;
        end
    end

endmodule

>>> rtl/core/lcdn_queue.sv
// ----------------------------------------------------------------------------
// lcdn_queue
// Short command queue between the request front end and the strobe sequencer.
// ----------------------------------------------------------------------------
module lcdn_queue
    import lcdn_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_desc,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_desc o_desc
);

    t_desc             r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr_ptr;
    logic [Q_AW-1:0]   r_rd_ptr;
    logic [Q_AW:0]     r_count;

    assign o_full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_desc  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> rtl/core/lcdn_back.sv
// ----------------------------------------------------------------------------
// lcdn_back
// Strobe sequencer: expands the command word at the queue head into enable
// strobe records, one per cycle unless stalled, into a registered output.
// ----------------------------------------------------------------------------
module lcdn_back
    import lcdn_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_head_valid,
    input  t_desc       i_head,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_rs,
    output logic [3:0]  o_nibble,
    output logic [15:0] o_pre_us,
    output logic [16:0] o_post_us,
    output logic        o_last
);

    logic [2:0]  r_step;   // init: strobe index; byte: bit 0 selects low nibble
    logic [4:0]  r_rep;    // repetitions already sent
    logic        r_valid;
    logic        r_rs;
    logic [3:0]  r_nib;
    logic [15:0] r_pre;
    logic [16:0] r_post;
    logic        r_last;

    logic        w_load;
    logic [3:0]  n_nib;
    logic [15:0] n_pre;
    logic [15:0] n_gap;
    logic        n_last;

    assign w_load = i_head_valid && (!r_valid || i_ready);
    assign o_pop  = w_load && n_last;

    always_comb begin
        n_pre = 16'd0;
        n_gap = 16'd0;
        if (i_head.op == OP_INIT) begin
            n_last = (r_step == 3'd7);
            unique case (r_step)
                3'd0, 3'd1, 3'd2: n_nib = NIB_INIT_A;
                3'd3:             n_nib = NIB_INIT_B;
                3'd4:             n_nib = i_head.data[7:4];
                3'd5:             n_nib = i_head.data[3:0];
                3'd6:             n_nib = CMD_CLEAR[7:4];
                default:          n_nib = CMD_CLEAR[3:0];
            endcase
            if (r_step == 3'd0) begin
                n_pre = i_cfg.power_up_us;
            end
            if (!r_step[2]) begin
                n_gap = i_cfg.init_gap_us;
            end else if (n_last) begin
                n_gap = i_cfg.clear_gap_us;
            end
        end else begin
            n_nib  = r_step[0] ? i_head.data[3:0] : i_head.data[7:4];
            n_last = r_step[0] && (r_rep == i_head.count - 5'd1);
            if (r_step[0] && i_head.clr_gap) begin
                n_gap = i_cfg.clear_gap_us;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= 3'd0;
            r_rep   <= 5'd0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            if (w_load) begin
                if (n_last) begin
                    r_step <= 3'd0;
                    r_rep  <= 5'd0;
                end else if (i_head.op == OP_INIT) begin
                    r_step <= r_step + 3'd1;
                end else begin
                    // advance to the next nibble, then to the next repetition
                    r_step <= {2'b00, ~r_step[0]};
                    if (r_step[0]) begin
                        r_rep <= r_rep + 5'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_rs   <= i_head.rs;
            r_nib  <= n_nib;
            r_pre  <= n_pre;
            r_post <= {7'd0, i_cfg.settle_us} + {1'b0, n_gap};
            r_last <= n_last;
        end
    end

    assign o_valid   = r_valid;
    assign o_rs      = r_rs;
    assign o_nibble  = r_nib;
    assign o_pre_us  = r_pre;
    assign o_post_us = r_post;
    assign o_last    = r_last;

    a_pop_marks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_valid && r_last))
        else $error("queue pop without a final strobe");

    a_pre_only_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && !(i_head.op == OP_INIT && r_step == 3'd0)) |=> (r_pre == 16'd0))
        else $error("pre-wait on a strobe other than the first init strobe");

    a_rep_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_head_valid && i_head.op == OP_BYTE) |-> (r_rep < i_head.count))
        else $error("repetition count overran the command");

    a_byte_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_head_valid && i_head.op == OP_BYTE) |-> (r_step[2:1] == 2'b00))
        else $error("byte command stepped past its low nibble");

endmodule
